// File: src/tmpl_pkg.sv
// Package for the triangle mesh point locator: sizes, codes, sequencer states.
// No dependencies; used by triangle_mesh_point_locator_top.
`timescale 1ns / 1ps
package tmpl_pkg;
    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int MAX_TRIANGLES_DEF = 2048;
    localparam int CNT_W    = 12;
    localparam int TOL_W    = 16;
    localparam int SLOT_W   = 11;
    localparam int CRN_W    = 10;
    localparam int COORD_W  = 32;
    localparam int BARY_W   = 18;
    localparam int PROD_W   = 66;   // 33 x 33 signed product
    localparam int SUM_W    = 67;   // sum of two products
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] FUNC_WR_VERTEX = 2'd0;
    localparam logic [1:0] FUNC_WR_TRI    = 2'd1;
    localparam logic [1:0] FUNC_LOCATE    = 2'd2;
    localparam logic [1:0] FUNC_NONE      = 2'd3;

    localparam logic CFG_TRI_COUNT = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    localparam logic signed [BARY_W-1:0] BARY_MAX = 18'sh1FFFF;
    localparam logic signed [BARY_W-1:0] BARY_MIN = 18'sh20000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TRI, ST_VA, ST_VB, ST_VC, ST_DIFF, ST_MUL, ST_DIVSET, ST_DIV,
        ST_CHECK, ST_OUT
    } state_t;
endpackage

// File: src/triangle_mesh_point_locator_top.sv
// Top level of the triangle mesh point locator: stores, sequencer, shared units.
// Depends on tmpl_pkg.
`timescale 1ns / 1ps
//  channel   | direction | handshake
//  ----------+-----------+-------------------------------------------
//  in        | input     | in_valid / in_ready, fields func..corner_c
//  out       | output    | out_valid / out_ready, found..bary_w
//  cfg       | input     | cfg_we, cfg_index, cfg_data (no wait)
//
// Vertex and triangle writes go straight to the store at the input transfer.
// A locate walks the triangles one by one through one shared 33x33 multiplier
// (six products) and one shared restoring divider (an overflow step plus 18
// quotient steps per coordinate, two coordinates); a degenerate triangle is
// dropped after the determinant, one with a bad corner before any multiply.
// Reset clears control and configuration; the stores hold no reset value.
// The result sits in an output register; in_ready stays low until it is taken.
module triangle_mesh_point_locator_top #(
    parameter int MAX_VERTICES  = tmpl_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = tmpl_pkg::MAX_TRIANGLES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] func,
    input  logic [tmpl_pkg::SLOT_W-1:0] slot,
    input  logic signed [tmpl_pkg::COORD_W-1:0] coord_x,
    input  logic signed [tmpl_pkg::COORD_W-1:0] coord_y,
    input  logic [tmpl_pkg::CRN_W-1:0] corner_a,
    input  logic [tmpl_pkg::CRN_W-1:0] corner_b,
    input  logic [tmpl_pkg::CRN_W-1:0] corner_c,
    output logic out_valid,
    input  logic out_ready,
    output logic found,
    output logic [tmpl_pkg::SLOT_W-1:0] hit_triangle,
    output logic signed [tmpl_pkg::BARY_W-1:0] bary_u,
    output logic signed [tmpl_pkg::BARY_W-1:0] bary_v,
    output logic signed [tmpl_pkg::BARY_W-1:0] bary_w,
    input  logic cfg_we,
    input  logic [tmpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmpl_pkg::CFG_DAT_W-1:0] cfg_data
);
    localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TA_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW   = tmpl_pkg::COORD_W;
    localparam int PW   = tmpl_pkg::PROD_W;
    localparam int SW   = tmpl_pkg::SUM_W;
    localparam int BW   = tmpl_pkg::BARY_W;
    localparam int DW   = SW + 16 + 2;   // divider working width

    // Memories: vertex {x,y}, triangle {a,b,c}.
    logic [2*CW-1:0]             vmem [MAX_VERTICES];
    logic [3*tmpl_pkg::CRN_W-1:0] tmem [MAX_TRIANGLES];
    logic [2*CW-1:0]             vrd_reg;
    logic [3*tmpl_pkg::CRN_W-1:0] trd_reg;
    logic [VA_W-1:0] vaddr;
    logic [TA_W-1:0] taddr;

    tmpl_pkg::state_t state_reg, state_next;

    logic [tmpl_pkg::CNT_W-1:0] tcount_reg;
    logic [tmpl_pkg::TOL_W-1:0] tol_reg;
    logic [tmpl_pkg::CNT_W-1:0] tri_reg, tri_next;   // triangle index, counts to n
    logic [tmpl_pkg::CNT_W-1:0] limit;
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    logic signed [CW:0] d0_reg, d1_reg, d2_reg, d3_reg, d4_reg, d5_reg;
    logic [2:0] mstep_reg;
    logic signed [SW-1:0] det_reg, nu_reg, nv_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [CW:0] ma, mb;
    logic sel_v_reg;
    logic [DW-1:0] rem_reg, dvs_reg;
    logic [BW-1:0] q_reg;
    logic [4:0] bit_reg;
    logic qneg_reg, qsat_reg;
    logic signed [BW-1:0] u_reg, v_reg;
    logic signed [BW-1:0] wsat;
    logic signed [BW+1:0] wraw;
    logic signed [BW:0] ntol;
    logic bad_corner;
    logic pass;

    logic out_valid_reg;
    logic found_reg;
    logic [tmpl_pkg::SLOT_W-1:0] hit_reg;
    logic signed [BW-1:0] ou_reg, ov_reg, ow_reg;

    logic in_xfer, out_xfer;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign in_ready = (state_reg == tmpl_pkg::ST_IDLE) && !out_valid_reg;

    assign limit = (32'(tcount_reg) > 32'(MAX_TRIANGLES))
                 ? tmpl_pkg::CNT_W'(MAX_TRIANGLES) : tcount_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcount_reg <= '0;
            tol_reg    <= tmpl_pkg::TOL_W'(7);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmpl_pkg::CFG_TRI_COUNT: tcount_reg <= cfg_data[tmpl_pkg::CNT_W-1:0];
                tmpl_pkg::CFG_TOLERANCE: tol_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Store writes happen at the input transfer; reads are registered.
    always_ff @(posedge clk)
    begin
        if (in_xfer && func == tmpl_pkg::FUNC_WR_VERTEX
            && 32'(slot) < 32'(MAX_VERTICES))
            vmem[slot[VA_W-1:0]] <= {coord_x, coord_y};
        if (in_xfer && func == tmpl_pkg::FUNC_WR_TRI
            && 32'(slot) < 32'(MAX_TRIANGLES))
            tmem[slot[TA_W-1:0]] <= {corner_a, corner_b, corner_c};
        vrd_reg <= vmem[vaddr];
        trd_reg <= tmem[taddr];
    end

    assign taddr = tri_reg[TA_W-1:0];
    always_comb
    begin
        case (state_reg)
            tmpl_pkg::ST_VA: vaddr = trd_reg[2*tmpl_pkg::CRN_W +: VA_W];
            tmpl_pkg::ST_VB: vaddr = trd_reg[tmpl_pkg::CRN_W +: VA_W];
            default:         vaddr = trd_reg[0 +: VA_W];
        endcase
    end
    assign bad_corner =
        32'(trd_reg[29:20]) >= 32'(MAX_VERTICES) ||
        32'(trd_reg[19:10]) >= 32'(MAX_VERTICES) ||
        32'(trd_reg[9:0])   >= 32'(MAX_VERTICES);

    // Shared multiplier operand select: six products over mstep 0..5.
    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin ma = d0_reg; mb = d1_reg; end  // (yb-yc)(xa-xc)
            3'd1:    begin ma = d2_reg; mb = d3_reg; end  // (xc-xb)(ya-yc)
            3'd2:    begin ma = d0_reg; mb = d4_reg; end  // (yb-yc)(px-xc)
            3'd3:    begin ma = d2_reg; mb = d5_reg; end  // (xc-xb)(py-yc)
            3'd4:    begin ma = -d3_reg; mb = d4_reg; end // (yc-ya)(px-xc)
            default: begin ma = d1_reg; mb = d5_reg; end  // (xa-xc)(py-yc)
        endcase
    end

    assign wraw = (BW+2)'(65536) - (BW+2)'(u_reg) - (BW+2)'(v_reg);
    assign wsat = (wraw > (BW+2)'(131071)) ? tmpl_pkg::BARY_MAX
                : (wraw < -(BW+2)'(131072)) ? tmpl_pkg::BARY_MIN : wraw[BW-1:0];
    assign ntol = -$signed({3'b000, tol_reg});
    assign pass = ((BW+1)'(u_reg) >= ntol) && ((BW+1)'(v_reg) >= ntol)
               && ((BW+1)'(wsat) >= ntol);

    // Final quotient including bit 0 decided this cycle.
    function automatic logic signed [BW-1:0] qval_last(
        input logic [DW-1:0] r, input logic [DW-1:0] d);
        logic [BW-1:0] q;
        q = q_reg;
        if (r >= d) q[0] = 1'b1;
        if (qsat_reg || q[BW-1])
            return qneg_reg ? tmpl_pkg::BARY_MIN : tmpl_pkg::BARY_MAX;
        return qneg_reg ? -$signed(q) : $signed(q);
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmpl_pkg::ST_IDLE:
                if (in_xfer && func == tmpl_pkg::FUNC_LOCATE)
                    state_next = tmpl_pkg::ST_TRI;
            tmpl_pkg::ST_TRI:
                state_next = (tri_reg >= limit) ? tmpl_pkg::ST_OUT : tmpl_pkg::ST_VA;
            tmpl_pkg::ST_VA:
                state_next = bad_corner ? tmpl_pkg::ST_TRI : tmpl_pkg::ST_VB;
            tmpl_pkg::ST_VB:   state_next = tmpl_pkg::ST_VC;
            tmpl_pkg::ST_VC:   state_next = tmpl_pkg::ST_DIFF;
            tmpl_pkg::ST_DIFF: state_next = tmpl_pkg::ST_MUL;
            tmpl_pkg::ST_MUL:
                if (mstep_reg == 3'd6)
                    state_next = tmpl_pkg::ST_DIVSET;
                else if (mstep_reg == 3'd3 && det_reg == '0)
                    state_next = tmpl_pkg::ST_TRI;
            tmpl_pkg::ST_DIVSET: state_next = tmpl_pkg::ST_DIV;
            tmpl_pkg::ST_DIV:
                if (bit_reg == 5'd0)
                    state_next = sel_v_reg ? tmpl_pkg::ST_CHECK : tmpl_pkg::ST_DIVSET;
            tmpl_pkg::ST_CHECK:
                state_next = pass ? tmpl_pkg::ST_OUT : tmpl_pkg::ST_TRI;
            tmpl_pkg::ST_OUT: state_next = tmpl_pkg::ST_IDLE;
            default: state_next = tmpl_pkg::ST_IDLE;
        endcase
    end

    // Triangle index: advance after every failed or skipped triangle.
    always_comb
    begin
        tri_next = tri_reg;
        case (state_reg)
            tmpl_pkg::ST_IDLE: tri_next = '0;
            tmpl_pkg::ST_VA:   if (bad_corner) tri_next = tri_reg + 1'b1;
            tmpl_pkg::ST_MUL:
                if (mstep_reg == 3'd3 && det_reg == '0) tri_next = tri_reg + 1'b1;
            tmpl_pkg::ST_CHECK: if (!pass) tri_next = tri_reg + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmpl_pkg::ST_IDLE;
            tri_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tri_reg   <= tri_next;
            if (state_reg == tmpl_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tmpl_pkg::ST_IDLE:
            begin
                px_reg <= coord_x;
                py_reg <= coord_y;
                // hold the previous result until a new item is taken
                if (in_xfer)
                    found_reg <= 1'b0;
            end
            tmpl_pkg::ST_VB: {xa_reg, ya_reg} <= vrd_reg;
            tmpl_pkg::ST_VC: {xb_reg, yb_reg} <= vrd_reg;
            tmpl_pkg::ST_DIFF:
            begin
                d0_reg <= (CW+1)'(yb_reg) - (CW+1)'($signed(vrd_reg[CW-1:0]));
                d1_reg <= (CW+1)'(xa_reg) - (CW+1)'($signed(vrd_reg[2*CW-1:CW]));
                d2_reg <= (CW+1)'($signed(vrd_reg[2*CW-1:CW])) - (CW+1)'(xb_reg);
                d3_reg <= (CW+1)'(ya_reg) - (CW+1)'($signed(vrd_reg[CW-1:0]));
                d4_reg <= (CW+1)'(px_reg) - (CW+1)'($signed(vrd_reg[2*CW-1:CW]));
                d5_reg <= (CW+1)'(py_reg) - (CW+1)'($signed(vrd_reg[CW-1:0]));
                mstep_reg <= 3'd0;
                sel_v_reg <= 1'b0;
            end
            tmpl_pkg::ST_MUL:
            begin
                // Product registered; accumulate the previous one.
                prod_reg  <= ma * mb;
                mstep_reg <= mstep_reg + 3'd1;
                case (mstep_reg)
                    3'd1: det_reg <= SW'(prod_reg);
                    3'd2: det_reg <= det_reg + SW'(prod_reg);
                    3'd3: nu_reg  <= SW'(prod_reg);
                    3'd4: nu_reg  <= nu_reg + SW'(prod_reg);
                    3'd5: nv_reg  <= SW'(prod_reg);
                    3'd6: nv_reg  <= nv_reg + SW'(prod_reg);
                    default: ;
                endcase
            end
            tmpl_pkg::ST_DIVSET:
            begin
                rem_reg  <= DW'(sel_v_reg ? (nv_reg[SW-1] ? -nv_reg : nv_reg)
                                          : (nu_reg[SW-1] ? -nu_reg : nu_reg)) << 16;
                dvs_reg  <= DW'(det_reg[SW-1] ? -det_reg : det_reg);
                qneg_reg <= (sel_v_reg ? nv_reg[SW-1] : nu_reg[SW-1]) ^ det_reg[SW-1];
                q_reg    <= '0;
                bit_reg  <= 5'd18;
                qsat_reg <= 1'b0;
            end
            tmpl_pkg::ST_DIV:
            begin
                // One quotient bit a cycle; step 18 checks overflow.
                if (rem_reg >= (dvs_reg << bit_reg))
                begin
                    if (bit_reg == 5'd18)
                        qsat_reg <= 1'b1;
                    else
                    begin
                        rem_reg <= rem_reg - (dvs_reg << bit_reg);
                        q_reg[bit_reg[4:0]] <= 1'b1;
                    end
                end
                if (bit_reg != 5'd0)
                    bit_reg <= bit_reg - 5'd1;
                else
                begin
                    sel_v_reg <= 1'b1;
                    if (sel_v_reg) v_reg <= qval_last(rem_reg, dvs_reg);
                    else           u_reg <= qval_last(rem_reg, dvs_reg);
                end
            end
            tmpl_pkg::ST_CHECK:
                if (pass)
                begin
                    found_reg <= 1'b1;
                    hit_reg   <= tri_reg[tmpl_pkg::SLOT_W-1:0];
                    ou_reg    <= u_reg;
                    ov_reg    <= v_reg;
                    ow_reg    <= wsat;
                end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign hit_triangle = found_reg ? hit_reg : '0;
    assign bary_u       = found_reg ? ou_reg : '0;
    assign bary_v       = found_reg ? ov_reg : '0;
    assign bary_w       = found_reg ? ow_reg : '0;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tmpl_pkg::ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmpl_pkg::ST_OUT) |=> out_valid)
        else $error("result not shown");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(found))
        else $error("result dropped");
endmodule
